// File: sv/dqs_pkg.sv
// Package for the double-ended queue with search: constants, payload and control types.
package dqs_pkg;

    localparam int DQS_DEPTH   = 16;
    localparam int DATA_W      = 32;
    localparam int OUT_COUNT_W = 5;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_SEARCH    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } state_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } dqs_in_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [OUT_COUNT_W-1:0] count;
    } dqs_out_t;

    typedef struct packed {
        logic exec;
        logic start_search;
        logic scan_issue;
        logic finish;
        logic found;
    } dqs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic hit;
        logic last_issue;
    } dqs_sts_t;

endpackage

// File: sv/deque_with_search.sv
// Top level: bounded double-ended queue of signed 32-bit values with linear search.
// Latency: insert, delete and search of an empty queue give their result the cycle after transfer.
// A search scans from the front until a hit; entries are read one per cycle from the entry RAM.
// One insert or delete per cycle if results are taken; a search holds the input for its scan.
// Reset clears the front pointer, the count and the control state; RAM contents stay undefined.
module deque_with_search #(
    parameter int DEPTH = dqs_pkg::DQS_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dqs_pkg::dqs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dqs_pkg::dqs_out_t out_data
);
    import dqs_pkg::*;

    dqs_cmd_t cmd;
    dqs_sts_t sts;

    dqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sv/dqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/dqs_ctrl.sv
// Controller state machine: accepts items and sequences the search scan.
module dqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  dqs_pkg::op_t      in_op,
    output logic              in_ready,
    input  dqs_pkg::dqs_sts_t sts,
    output dqs_pkg::dqs_cmd_t cmd
);
    import dqs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = sts.out_free;
                if (accept)
                begin
                    if (in_op == OP_SEARCH && !sts.empty)
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = S_SCAN;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.found  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    if (sts.last_issue)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                cmd.finish = 1'b1;
                cmd.found  = sts.hit;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/dqs_dp.sv
// Datapath: ring pointers, entry RAM, scan address generator, compare and result register.
module dqs_dp #(
    parameter int DEPTH = dqs_pkg::DQS_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dqs_pkg::dqs_in_t  in_data,
    input  logic              out_ready,
    output logic              out_valid,
    output dqs_pkg::dqs_out_t out_data,
    input  dqs_pkg::dqs_cmd_t cmd,
    output dqs_pkg::dqs_sts_t sts
);
    import dqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    logic [AW-1:0]     front_reg;
    logic [AW-1:0]     front_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     addr_reg;
    logic [DATA_W-1:0] key_reg;
    logic              cmp_valid_reg;
    logic              out_valid_reg;
    dqs_out_t          out_data_reg;
    dqs_out_t          res_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] rdata;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     front_inc;
    logic [AW-1:0]     addr_inc;
    logic [SW-1:0]     back_sum;
    logic [AW-1:0]     back_pos;
    logic              full;
    logic              empty;
    logic              out_load;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_POS) ? '0 : front_reg + AW'(1);
    assign addr_inc  = (addr_reg == LAST_POS) ? '0 : addr_reg + AW'(1);
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_pos  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        we             = 1'b0;
        waddr          = back_pos;
        res_next       = '0;
        res_next.status = ST_OK;
        if (cmd.exec)
        begin
            case (in_data.op)
                OP_INS_FRONT:
                begin
                    if (full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        we         = 1'b1;
                        waddr      = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_INS_BACK:
                begin
                    if (full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DEL_FRONT:
                begin
                    if (empty)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_DEL_BACK:
                begin
                    if (empty)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.finish)
        begin
            res_next.found = cmd.found;
        end
        res_next.count = OUT_COUNT_W'(count_next);
    end

    assign out_load = cmd.exec || cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmd.scan_issue;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_next;
        end
        if (cmd.start_search)
        begin
            key_reg  <= in_data.value;
            idx_reg  <= '0;
            addr_reg <= front_reg;
        end
        else if (cmd.scan_issue)
        begin
            idx_reg  <= idx_reg + AW'(1);
            addr_reg <= addr_inc;
        end
    end

    dqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_data.value),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.empty      = empty;
    assign sts.hit        = cmp_valid_reg && (rdata == key_reg);
    assign sts.last_issue = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/deque_with_search_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
module deque_with_search_chk #(
    parameter int DEPTH = dqs_pkg::DQS_DEPTH
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input dqs_pkg::dqs_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input dqs_pkg::dqs_out_t out_data
);
    import dqs_pkg::*;

    localparam logic [OUT_COUNT_W-1:0] FULL_COUNT = OUT_COUNT_W'(DEPTH);

    // held result must not change until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an input transfer never overruns a waiting result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("input taken while result stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |-> out_data.count == FULL_COUNT)
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
        else $error("empty status with nonzero count");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.status == ST_OK)
        else $error("found flag with error status");

endmodule

bind deque_with_search deque_with_search_chk #(.DEPTH(DEPTH)) u_chk (.*);

// File: sim/tb.sv
// Testbench for deque_with_search: directed and random operations checked against a ring predictor.
`timescale 1ns / 100ps

module tb;
    import dqs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 80;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_N      = 8;

    typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED, PH_SEARCH } phase_t;

    typedef struct {
        dqs_in_t item;
        int      gap;
        bit      drain;
    } pending_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    dqs_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    dqs_out_t out_data;

    pending_t   pend_q[$];
    dqs_out_t   expected_q[$];
    logic [31:0] ring_mem[DQS_DEPTH];
    int         ring_front;
    int         ring_count;
    int         n_total;
    int         n_sent;
    int         n_done;
    int         n_errors;
    int         n_full;
    int         n_empty;
    int         n_hits;
    int         cycles;
    int         gap_left;
    int         stall_left;
    bit         hold_done;
    logic [31:0] val_pool[POOL_N];
    int         pool_wr;

    deque_with_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    function automatic dqs_out_t deque_predict(dqs_in_t item);
        dqs_out_t res;
        res.status = ST_OK;
        res.found  = 1'b0;
        case (item.op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (ring_count >= DQS_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else if (item.op == OP_INS_FRONT)
                begin
                    ring_front = (ring_front + DQS_DEPTH - 1) % DQS_DEPTH;
                    ring_mem[ring_front] = item.value;
                    ring_count++;
                end
                else
                begin
                    ring_mem[(ring_front + ring_count) % DQS_DEPTH] = item.value;
                    ring_count++;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (ring_count == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    if (item.op == OP_DEL_FRONT)
                        ring_front = (ring_front + 1) % DQS_DEPTH;
                    ring_count--;
                end
            end
            OP_SEARCH:
            begin
                for (int i = 0; i < ring_count; i++)
                    if (ring_mem[(ring_front + i) % DQS_DEPTH] == item.value)
                        res.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.count = ring_count[OUT_COUNT_W-1:0];
        return res;
    endfunction

    task automatic queue_op(op_t op, logic [31:0] value, int gap, bit drain);
        pending_t p;
        p.item.op    = op;
        p.item.value = value;
        p.gap        = gap;
        p.drain      = drain;
        pend_q.push_back(p);
        if (op == OP_INS_FRONT || op == OP_INS_BACK)
        begin
            val_pool[pool_wr] = value;
            pool_wr = (pool_wr + 1) % POOL_N;
        end
    endtask

    function automatic logic [31:0] pick_value(int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < pool_pct)
            return val_pool[$urandom_range(0, POOL_N - 1)];
        else if (r < pool_pct + 5)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom;
    endfunction

    function automatic op_t pick_op(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return op_t'(OP_SEARCH + $urandom_range(1, 3));
        case (ph)
            PH_FILL:   r = (r < 78) ? 0 : (r < 88) ? 2 : 4;
            PH_DRAIN:  r = (r < 15) ? 0 : (r < 80) ? 2 : 4;
            PH_SEARCH: r = (r < 30) ? 0 : (r < 40) ? 2 : 4;
            default:   r = (r < 40) ? 0 : (r < 75) ? 2 : 4;
        endcase
        if (r == 4)
            return OP_SEARCH;
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? OP_INS_BACK : OP_INS_FRONT;
        return ($urandom_range(0, 1) != 0) ? OP_DEL_BACK : OP_DEL_FRONT;
    endfunction

    task automatic build_stimulus();
        phase_t ph;
        int     len;
        bit     gaps_on;
        op_t    op;
        for (int i = 0; i < POOL_N; i++)
            val_pool[i] = $urandom;
        pool_wr = 0;

        // directed: empty cases, unused codes, extreme values, hit and miss
        queue_op(OP_SEARCH, 32'h0000_0000, 0, 1'b0);
        queue_op(OP_DEL_FRONT, 32'hffff_ffff, 0, 1'b0);
        queue_op(OP_DEL_BACK, 32'h0000_0000, 0, 1'b0);
        for (int k = 1; k <= 3; k++)
            queue_op(op_t'(OP_SEARCH + k), 32'h1234_5678, 0, 1'b0);
        queue_op(OP_INS_FRONT, 32'h8000_0000, 0, 1'b0);
        queue_op(OP_INS_BACK, 32'h7fff_ffff, 0, 1'b0);
        queue_op(OP_INS_FRONT, 32'h0000_0000, 0, 1'b0);
        queue_op(OP_INS_BACK, 32'hffff_ffff, 0, 1'b0);
        queue_op(OP_SEARCH, 32'h8000_0000, 0, 1'b0);
        queue_op(OP_SEARCH, 32'h7fff_ffff, 0, 1'b0);
        queue_op(OP_SEARCH, 32'hffff_ffff, 0, 1'b0);
        queue_op(OP_SEARCH, 32'h0000_0001, 0, 1'b0);
        queue_op(op_t'(OP_SEARCH + 2), 32'h0000_0000, 0, 1'b0);
        queue_op(OP_DEL_FRONT, 32'h0, 0, 1'b0);
        queue_op(OP_DEL_BACK, 32'h0, 0, 1'b0);
        queue_op(OP_SEARCH, 32'h8000_0000, 0, 1'b0);
        queue_op(OP_DEL_FRONT, 32'h0, 0, 1'b0);
        queue_op(OP_DEL_BACK, 32'h0, 0, 1'b0);
        queue_op(OP_DEL_BACK, 32'h0, 0, 1'b0);
        queue_op(OP_INS_BACK, 32'h5555_5555, 0, 1'b0);
        queue_op(OP_INS_FRONT, 32'haaaa_aaaa, 0, 1'b0);
        queue_op(OP_SEARCH, 32'haaaa_aaaa, 0, 1'b0);

        // random phases; first one is forced to fill so the full case shows up early
        ph = PH_FILL;
        while (pend_q.size() < 720)
        begin
            len = $urandom_range(20, 60);
            gaps_on = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < len; i++)
            begin
                op = pick_op(ph);
                queue_op(op, pick_value(op == OP_SEARCH ? 60 : 40),
                         (gaps_on && $urandom_range(0, 99) < 20 &&
                          pend_q.size() < 720 - QUIET_TAIL) ? $urandom_range(1, 14) : 0,
                         i == 0);
            end
            ph = phase_t'($urandom_range(0, 3));
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(deque_predict(in_data));
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pend_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_q[0].drain && expected_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data  <= pend_q[0].item;
                    in_valid <= 1'b1;
                    pend_q.pop_front();
                    gap_left = (pend_q.size() != 0) ? pend_q[0].gap : 0;
                end
            end
        end
    end

    // receiver stalls, including one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_done  = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && n_sent >= HOLD_AT)
        begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (n_sent < n_total - QUIET_TAIL && (n_sent / 100) % 3 != 1 &&
                 $urandom_range(0, 99) < 12)
        begin
            stall_left = $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dqs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_done++;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result with none pending: status=%0d found=%0d count=%0d",
                             out_data.status, out_data.found, out_data.count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.status !== want.status || out_data.found !== want.found ||
                    out_data.count !== want.count)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"ERROR: transfer %0d expected status=%0d found=%0d ",
                                  "count=%0d, got status=%0d found=%0d count=%0d"},
                                 n_done, want.status, want.found, want.count,
                                 out_data.status, out_data.found, out_data.count);
                end
                if (want.status == ST_FULL)
                    n_full++;
                if (want.status == ST_EMPTY)
                    n_empty++;
                if (want.found)
                    n_hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d results seen",
                     cycles, n_done, n_total);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        ring_front = 0;
        ring_count = 0;
        n_sent     = 0;
        n_done     = 0;
        n_errors   = 0;
        n_full     = 0;
        n_empty    = 0;
        n_hits     = 0;
        cycles     = 0;
        build_stimulus();
        n_total = pend_q.size();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (n_sent < n_total || expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Ran %0d transfers: %0d inserts into a full queue, %0d deletes from an empty one,",
                 n_done, n_full, n_empty);
        $display("%0d search hits, with random stalls on both sides and one long output hold-off.",
                 n_hits);
        if (n_errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: deque_with_search.f
sv/dqs_pkg.sv
sv/dqs_ram.sv
sv/dqs_ctrl.sv
sv/dqs_dp.sv
sv/deque_with_search.sv
sv/deque_with_search_chk.sv
sim/tb.sv
